/* hw/rtl/line_draw_pixel_engine_unit_assert.svh */
// Assertion macros shared by the line drawing pixel engine RTL.
`ifndef LINE_DRAW_PIXEL_ENGINE_UNIT_ASSERT_SVH
`define LINE_DRAW_PIXEL_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LDPE_ASSERT_IMPLY(name, clk, rst_n, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LDPE_ASSERT_NEXT(name, clk, rst_n, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

/* hw/rtl/ldpe_pkg.sv */
// Shared types, constants and helpers of the line drawing pixel engine.
package ldpe_pkg;

  localparam int unsigned COORD_W   = 12;
  localparam int unsigned COLOR_W   = 15;
  localparam int unsigned WORD_W    = 16;
  localparam int unsigned DIM_W     = 9;
  localparam int unsigned MODE_W    = 3;
  localparam int unsigned CFG_IDX_W = 3;

  localparam int unsigned MAX_WIDTH_DEF  = 256;
  localparam int unsigned MAX_HEIGHT_DEF = 256;

  localparam logic [DIM_W-1:0]   WIDTH_RST  = 9'd256;
  localparam logic [DIM_W-1:0]   HEIGHT_RST = 9'd192;
  localparam logic [COLOR_W-1:0] COLOR_RST  = 15'd0;

  typedef enum logic [MODE_W-1:0] {
    MODE_MOVE_TO   = 3'd0,
    MODE_LINE_TO   = 3'd1,
    MODE_SET_PIXEL = 3'd2,
    MODE_GET_PIXEL = 3'd3,
    MODE_FILL      = 3'd4,
    MODE_CLEAR     = 3'd5
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CANVAS_WIDTH  = 3'd0,
    CFG_CANVAS_HEIGHT = 3'd1,
    CFG_PEN_COLOR     = 3'd2,
    CFG_BRUSH_COLOR   = 3'd3
  } cfg_idx_e;

  typedef enum logic [7:0] {
    ST_INIT  = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_LINE  = 8'b0000_0100,
    ST_PLOT  = 8'b0000_1000,
    ST_RADDR = 8'b0001_0000,
    ST_SIZE  = 8'b0010_0000,
    ST_SWEEP = 8'b0100_0000,
    ST_RESP  = 8'b1000_0000
  } state_e;

  // Active canvas size after limiting to the store dimensions.
  typedef struct packed {
    logic [DIM_W-1:0] act_w;
    logic [DIM_W-1:0] act_h;
  } canvas_t;

  // One point produced by the line walker.
  typedef struct packed {
    logic                      vld;
    logic                      last;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } walk_t;

  // One pixel request entering the address stage.
  typedef struct packed {
    logic                      vld;
    logic                      wr;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [COLOR_W-1:0]        color;
  } point_t;

  // Registered result of the address stage; the address travels beside it.
  typedef struct packed {
    logic               hit;
    logic               wr;
    logic [COLOR_W-1:0] color;
  } req_t;

  // A written pixel always carries the opaque bit.
  function automatic logic [WORD_W-1:0] pixel_word(logic [COLOR_W-1:0] color);
    return {1'b1, color};
  endfunction

endpackage

/* hw/rtl/ldpe_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
module ldpe_ram #(
  parameter  int unsigned Width = 16,
  parameter  int unsigned Depth = 256,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/ldpe_walker.sv */
// Iterative line walker: one error add, compare and subtract per plotted point.
module ldpe_walker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [ldpe_pkg::COORD_W-1:0] pen_x_i,
  input  logic signed [ldpe_pkg::COORD_W-1:0] pen_y_i,
  input  logic signed [ldpe_pkg::COORD_W-1:0] tgt_x_i,
  input  logic signed [ldpe_pkg::COORD_W-1:0] tgt_y_i,
  output ldpe_pkg::walk_t                     walk_o
);

  localparam int unsigned CW = ldpe_pkg::COORD_W;

  logic          setup_q, run_q;
  logic [CW-1:0] x_q, y_q, tgt_x_q, tgt_y_q;
  logic [CW-1:0] dmaj_q, dmin_q, cnt_q, err_q;
  logic          xmaj_q, sx_neg_q, sy_neg_q;

  logic [CW:0]   dx, dy, adx_w, ady_w;
  logic [CW-1:0] adx, ady;
  logic          xmaj;
  logic [CW:0]   err_sum;
  logic          adv, last;
  logic [CW-1:0] x_step, y_step, err_d;

  // Setup: signed differences and their magnitudes (at most 4095).
  assign dx    = {tgt_x_q[CW-1], tgt_x_q} - {x_q[CW-1], x_q};
  assign dy    = {tgt_y_q[CW-1], tgt_y_q} - {y_q[CW-1], y_q};
  assign adx_w = dx[CW] ? (~dx + 1'b1) : dx;
  assign ady_w = dy[CW] ? (~dy + 1'b1) : dy;
  assign adx   = adx_w[CW-1:0];
  assign ady   = ady_w[CW-1:0];
  assign xmaj  = adx > ady;

  // Step: the minor axis advances when the error exceeds the major difference.
  assign err_sum = {1'b0, err_q} + {1'b0, dmin_q};
  assign adv     = err_sum > {1'b0, dmaj_q};
  assign err_d   = adv ? CW'(err_sum - {1'b0, dmaj_q}) : err_sum[CW-1:0];
  assign x_step  = x_q + (sx_neg_q ? {CW{1'b1}} : CW'(1));
  assign y_step  = y_q + (sy_neg_q ? {CW{1'b1}} : CW'(1));
  assign last    = (cnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setup_q <= 1'b0;
      run_q   <= 1'b0;
    end else begin
      if (start_i) begin
        setup_q <= 1'b1;
      end else if (setup_q) begin
        setup_q <= 1'b0;
        run_q   <= 1'b1;
      end else if (run_q && last) begin
        run_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q     <= pen_x_i;
      y_q     <= pen_y_i;
      tgt_x_q <= tgt_x_i;
      tgt_y_q <= tgt_y_i;
    end else if (setup_q) begin
      xmaj_q   <= xmaj;
      sx_neg_q <= dx[CW];
      sy_neg_q <= dy[CW];
      dmaj_q   <= xmaj ? adx : ady;
      dmin_q   <= xmaj ? ady : adx;
      cnt_q    <= xmaj ? adx : ady;
      err_q    <= '0;
    end else if (run_q) begin
      cnt_q <= cnt_q - 1'b1;
      err_q <= err_d;
      if (xmaj_q) begin
        x_q <= x_step;
        if (adv) begin
          y_q <= y_step;
        end
      end else begin
        y_q <= y_step;
        if (adv) begin
          x_q <= x_step;
        end
      end
    end
  end

  assign walk_o.vld  = run_q;
  assign walk_o.last = last;
  assign walk_o.x    = x_q;
  assign walk_o.y    = y_q;

endmodule

/* hw/rtl/ldpe_addr.sv */
// Clipping and address stage: canvas test and y * width + x, registered.
module ldpe_addr #(
  parameter int unsigned AddrW = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ldpe_pkg::canvas_t canvas_i,
  input  ldpe_pkg::point_t  pt_i,
  output ldpe_pkg::req_t    req_o,
  output logic [AddrW-1:0]  addr_o
);

  localparam int unsigned CW    = ldpe_pkg::COORD_W;
  localparam int unsigned DimW  = ldpe_pkg::DIM_W;
  localparam int unsigned ProdW = 2 * DimW;

  logic             in_canvas;
  logic [ProdW-1:0] prod;
  logic [ProdW:0]   sum;
  logic             hit_q, wr_q;
  logic [ldpe_pkg::COLOR_W-1:0] color_q;
  logic [AddrW-1:0] addr_q;

  assign in_canvas = !pt_i.x[CW-1] && !pt_i.y[CW-1]
                  && (pt_i.x[CW-2:0] < (CW-1)'(canvas_i.act_w))
                  && (pt_i.y[CW-2:0] < (CW-1)'(canvas_i.act_h));

  // Only meaningful when inside, where both coordinates fit the dimension width.
  assign prod = ProdW'(pt_i.y[DimW-1:0]) * ProdW'(canvas_i.act_w);
  assign sum  = (ProdW+1)'(prod) + (ProdW+1)'(pt_i.x[DimW-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= pt_i.vld && in_canvas;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pt_i.vld) begin
      wr_q    <= pt_i.wr;
      color_q <= pt_i.color;
      addr_q  <= AddrW'(sum);
    end
  end

  assign req_o.hit   = hit_q;
  assign req_o.wr    = wr_q;
  assign req_o.color = color_q;
  assign addr_o      = addr_q;

endmodule

/* hw/rtl/line_draw_pixel_engine_unit.sv */
// Top level of the line drawing pixel engine: sequencer, registers, store.
//
// Commands arrive as transactions on the in_* channel (mode, x, y, colour) and
// every command returns exactly one transaction on the out_* channel carrying
// read_color, which is the stored colour for a get-pixel inside the canvas and
// zero in every other case. Registers are written on the cfg_* channel, which
// is always ready and should only be used while no command is in flight.
// The engine works on one command at a time; in_ready_o is high only while
// the sequencer is idle. Lines and fills are bounded by the single write port
// of the frame store, which takes one pixel per cycle.
// After reset the engine sweeps the whole store to zero, one word per cycle;
// no command is taken meanwhile, though register writes are. The result sits
// in an output register, so a stalled receiver does not hold up the next
// command: only the following result waits until the previous one has been
// taken.
`include "line_draw_pixel_engine_unit_assert.svh"

module line_draw_pixel_engine_unit #(
  parameter int unsigned MaxWidth  = ldpe_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MaxHeight = ldpe_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Command channel.
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [ldpe_pkg::MODE_W-1:0]          mode_i,
  input  logic signed [ldpe_pkg::COORD_W-1:0]  x_coord_i,
  input  logic signed [ldpe_pkg::COORD_W-1:0]  y_coord_i,
  input  logic [ldpe_pkg::COLOR_W-1:0]         pixel_color_i,
  // Result channel.
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [ldpe_pkg::COLOR_W-1:0]         read_color_o,
  // Register write channel.
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [ldpe_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [ldpe_pkg::COLOR_W-1:0]         cfg_data_i
);

  localparam int unsigned Depth  = MaxWidth * MaxHeight;
  localparam int unsigned AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned SweepW = $clog2(Depth + 1);
  localparam int unsigned DimW   = ldpe_pkg::DIM_W;
  localparam int unsigned CW     = ldpe_pkg::COORD_W;
  localparam int unsigned ColW   = ldpe_pkg::COLOR_W;
  localparam int unsigned WordW  = ldpe_pkg::WORD_W;

  ldpe_pkg::state_e state_q, state_d;

  // Configuration registers.
  logic [DimW-1:0] canvas_width_q, canvas_height_q;
  logic [ColW-1:0] pen_color_q, brush_color_q;

  // Latched command and pen position.
  logic [ldpe_pkg::MODE_W-1:0] cmd_mode_q;
  logic signed [CW-1:0]        cmd_x_q, cmd_y_q, pen_x_q, pen_y_q, pen_x_d, pen_y_d;
  logic [ColW-1:0]             cmd_color_q;

  // Sweep counter, shared by the reset clearing pass and by fill and clear.
  logic [SweepW-1:0] sweep_cnt_q, sweep_cnt_d, sweep_end_q, sweep_end_d;
  logic [2*DimW-1:0] canvas_area;

  logic            rd_hit_q, rd_hit_d;
  logic            out_valid_q, out_valid_d;
  logic [ColW-1:0] out_color_q, out_color_d;

  ldpe_pkg::canvas_t canvas;
  ldpe_pkg::walk_t   walk;
  ldpe_pkg::point_t  pt;
  ldpe_pkg::req_t    req;
  logic [AddrW-1:0]  req_addr;

  logic             in_accept, walk_start;
  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr;
  logic [WordW-1:0] ram_wdata, ram_rdata;

  assign in_ready_o = (state_q == ldpe_pkg::ST_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;
  assign walk_start = in_accept && (mode_i == ldpe_pkg::MODE_LINE_TO);

  // The active canvas is limited to the dimensions of the store.
  assign canvas.act_w = (32'(canvas_width_q) < MaxWidth) ? canvas_width_q : DimW'(MaxWidth);
  assign canvas.act_h = (32'(canvas_height_q) < MaxHeight) ? canvas_height_q
                                                            : DimW'(MaxHeight);
  assign canvas_area  = (2*DimW)'(canvas.act_w) * (2*DimW)'(canvas.act_h);

  // Register writes; an index beyond the list is ignored.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      canvas_width_q  <= ldpe_pkg::WIDTH_RST;
      canvas_height_q <= ldpe_pkg::HEIGHT_RST;
      pen_color_q     <= ldpe_pkg::COLOR_RST;
      brush_color_q   <= ldpe_pkg::COLOR_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ldpe_pkg::CFG_CANVAS_WIDTH:  canvas_width_q  <= cfg_data_i[DimW-1:0];
        ldpe_pkg::CFG_CANVAS_HEIGHT: canvas_height_q <= cfg_data_i[DimW-1:0];
        ldpe_pkg::CFG_PEN_COLOR:     pen_color_q     <= cfg_data_i;
        ldpe_pkg::CFG_BRUSH_COLOR:   brush_color_q   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // The walker emits one line point per cycle once it has set up.
  ldpe_walker u_walker (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (walk_start),
    .pen_x_i (pen_x_q),
    .pen_y_i (pen_y_q),
    .tgt_x_i (x_coord_i),
    .tgt_y_i (y_coord_i),
    .walk_o  (walk)
  );

  // Line points and single-pixel commands share the clipping and address stage.
  always_comb begin
    pt.vld   = walk.vld || (state_q == ldpe_pkg::ST_PLOT);
    pt.wr    = walk.vld || (cmd_mode_q == ldpe_pkg::MODE_SET_PIXEL);
    pt.x     = walk.vld ? walk.x : cmd_x_q;
    pt.y     = walk.vld ? walk.y : cmd_y_q;
    pt.color = walk.vld ? pen_color_q : cmd_color_q;
  end

  ldpe_addr #(
    .AddrW (AddrW)
  ) u_addr (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .canvas_i (canvas),
    .pt_i     (pt),
    .req_o    (req),
    .addr_o   (req_addr)
  );

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    pen_x_d     = pen_x_q;
    pen_y_d     = pen_y_q;
    sweep_cnt_d = sweep_cnt_q;
    sweep_end_d = sweep_end_q;
    rd_hit_d    = rd_hit_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_color_d = out_color_q;
    // Outside the sweeps the store is written from the address stage.
    ram_we      = req.hit && req.wr;
    ram_waddr   = req_addr;
    ram_wdata   = ldpe_pkg::pixel_word(req.color);
    ram_re      = 1'b0;

    case (state_q)
      ldpe_pkg::ST_INIT: begin
        if (sweep_cnt_q == SweepW'(Depth)) begin
          sweep_cnt_d = '0;
          state_d     = ldpe_pkg::ST_IDLE;
        end else begin
          ram_we      = 1'b1;
          ram_waddr   = AddrW'(sweep_cnt_q);
          ram_wdata   = '0;
          sweep_cnt_d = sweep_cnt_q + 1'b1;
        end
      end
      ldpe_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          case (mode_i)
            ldpe_pkg::MODE_MOVE_TO: begin
              pen_x_d = x_coord_i;
              pen_y_d = y_coord_i;
              state_d = ldpe_pkg::ST_RESP;
            end
            ldpe_pkg::MODE_LINE_TO:   state_d = ldpe_pkg::ST_LINE;
            ldpe_pkg::MODE_SET_PIXEL: state_d = ldpe_pkg::ST_PLOT;
            ldpe_pkg::MODE_GET_PIXEL: state_d = ldpe_pkg::ST_PLOT;
            ldpe_pkg::MODE_FILL:      state_d = ldpe_pkg::ST_SIZE;
            ldpe_pkg::MODE_CLEAR:     state_d = ldpe_pkg::ST_SIZE;
            default:                  state_d = ldpe_pkg::ST_RESP;
          endcase
        end
      end
      ldpe_pkg::ST_LINE: begin
        if (walk.vld && walk.last) begin
          pen_x_d = cmd_x_q;
          pen_y_d = cmd_y_q;
          state_d = ldpe_pkg::ST_RESP;
        end
      end
      ldpe_pkg::ST_PLOT: begin
        state_d = (cmd_mode_q == ldpe_pkg::MODE_GET_PIXEL) ? ldpe_pkg::ST_RADDR
                                                           : ldpe_pkg::ST_RESP;
      end
      ldpe_pkg::ST_RADDR: begin
        ram_re   = 1'b1;
        rd_hit_d = req.hit;
        state_d  = ldpe_pkg::ST_RESP;
      end
      ldpe_pkg::ST_SIZE: begin
        sweep_end_d = SweepW'(canvas_area);
        sweep_cnt_d = '0;
        state_d     = ldpe_pkg::ST_SWEEP;
      end
      ldpe_pkg::ST_SWEEP: begin
        if (sweep_cnt_q == sweep_end_q) begin
          state_d = ldpe_pkg::ST_RESP;
        end else begin
          ram_we      = 1'b1;
          ram_waddr   = AddrW'(sweep_cnt_q);
          ram_wdata   = (cmd_mode_q == ldpe_pkg::MODE_FILL)
                      ? ldpe_pkg::pixel_word(brush_color_q) : '0;
          sweep_cnt_d = sweep_cnt_q + 1'b1;
        end
      end
      ldpe_pkg::ST_RESP: begin
        // Hand the result over once the output register is free.
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_color_d = ((cmd_mode_q == ldpe_pkg::MODE_GET_PIXEL) && rd_hit_q)
                      ? ram_rdata[ColW-1:0] : '0;
          state_d     = ldpe_pkg::ST_IDLE;
        end
      end
      default: state_d = ldpe_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ldpe_pkg::ST_INIT;
      sweep_cnt_q <= '0;
      pen_x_q     <= '0;
      pen_y_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_cnt_q <= sweep_cnt_d;
      pen_x_q     <= pen_x_d;
      pen_y_q     <= pen_y_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_mode_q  <= mode_i;
      cmd_x_q     <= x_coord_i;
      cmd_y_q     <= y_coord_i;
      cmd_color_q <= pixel_color_i;
    end
    sweep_end_q <= sweep_end_d;
    rd_hit_q    <= rd_hit_d;
    out_color_q <= out_color_d;
  end

  ldpe_ram #(
    .Width (WordW),
    .Depth (Depth)
  ) u_frame_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (req_addr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o  = out_valid_q;
  assign read_color_o = out_color_q;

  // An accepted command always takes the sequencer out of idle.
  `LDPE_ASSERT_NEXT(a_accept_leaves_idle, clk_i, rst_ni, in_accept, state_q != ldpe_pkg::ST_IDLE, "accepted command left the sequencer idle")
  // Pixel writes from the address stage must have drained before any sweep.
  `LDPE_ASSERT_IMPLY(a_no_pixel_in_sweep, clk_i, rst_ni, (state_q == ldpe_pkg::ST_SWEEP) || (state_q == ldpe_pkg::ST_INIT), !req.hit, "pixel request collides with a store sweep")
  // The walker only produces points while a line command is in progress.
  `LDPE_ASSERT_IMPLY(a_walk_in_line, clk_i, rst_ni, walk.vld, state_q == ldpe_pkg::ST_LINE, "line point outside a line command")

endmodule
